>>> sv/assert_macros.svh
// assertion macros used by the checker file rtmpm_checker.sv
// no dependencies; clock i_clk and active-low reset i_rst_n are assumed in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("assertion failed");

// antecedent in one cycle implies consequent in the next
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> sv/rtmpm_pkg.sv
// shared types and constants of the reverse trie pattern matcher
// no dependencies
package rtmpm_pkg;

    localparam logic [1:0] ACT_EDGE = 2'd0;
    localparam logic [1:0] ACT_MARK = 2'd1;
    localparam logic [1:0] ACT_SKIP = 2'd2;
    localparam logic [1:0] ACT_TEXT = 2'd3;

    localparam int NODE_FW  = 6;
    localparam int PAT_FW   = 6;
    localparam int SKIP_FW  = 7;
    localparam int START_FW = 10;
    localparam int MARK_W   = PAT_FW + 1;
    localparam int MIN_W    = 7;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_LOAD,
        S_WIN,
        S_TXT,
        S_SYM,
        S_EDGE,
        S_MARK,
        S_SKIP,
        S_ADV,
        S_RD,
        S_SHOW
    } t_state;

endpackage

>>> sv/rtmpm_ram.sv
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module rtmpm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

>>> sv/reverse_trie_multi_pattern_matcher_core.sv
// top level of the reverse trie multi-pattern matcher
// depends on rtmpm_pkg and rtmpm_ram
//
// After reset the block sweeps its edge, mark and skip memories to zero, one
// edge entry per cycle over all TRIE_NODES * 2**SYMBOL_BITS entries (16384
// with the defaults), during which no input beat is taken; configuration
// writes are taken throughout. Table writes and text symbols are then taken
// one beat per cycle. The text beat flagged as last starts the search: each
// window reads its last text symbol, each trie step reads the edge, mark and
// text memories one after another, and when the walk ends the skip memory is
// read to advance the window; a walk that reaches the start of the text ends
// after its mark read without a further lookup. Matches are gathered in a
// small result memory and delivered one at a time, each read from it after
// the last is taken; while a search or its delivery runs no input beat is
// taken. A search with no match delivers a single end marker.
module reverse_trie_multi_pattern_matcher_core #(
    parameter int TRIE_NODES  = 64,
    parameter int SYMBOL_BITS = 8,
    parameter int TEXT_DEPTH  = 1024,
    parameter int MAX_MATCHES = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // configuration
    input  logic       i_cfg_we,
    input  logic [6:0] i_cfg_wdata,
    // input channel
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [1:0] i_action,
    input  logic [5:0] i_node,
    input  logic [7:0] i_symbol,
    input  logic [5:0] i_child_node,
    input  logic       i_has_pattern,
    input  logic [5:0] i_pattern_id,
    input  logic [6:0] i_skip_value,
    input  logic       i_last_symbol,
    // result channel
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic       o_found,
    output logic [5:0] o_match_pattern,
    output logic [9:0] o_match_start,
    output logic       o_overflow,
    output logic       o_end_of_search
);
    localparam int SB        = SYMBOL_BITS;
    localparam int SYM_COUNT = 1 << SYMBOL_BITS;
    localparam int NW        = $clog2(TRIE_NODES);
    localparam int EAW       = NW + SB;
    localparam int EDEPTH    = TRIE_NODES * SYM_COUNT;
    localparam int TAW       = TEXT_DEPTH > 1 ? $clog2(TEXT_DEPTH) : 1;
    localparam int TLW       = $clog2(TEXT_DEPTH + 1);
    localparam int PW        = TLW + 8;
    localparam int CW        = $clog2(MAX_MATCHES + 1);
    localparam int MAW       = MAX_MATCHES > 1 ? $clog2(MAX_MATCHES) : 1;
    localparam int MDW       = rtmpm_pkg::PAT_FW + rtmpm_pkg::START_FW;

    rtmpm_pkg::t_state r_state, n_state;

    logic [EAW-1:0]              r_clr, n_clr;
    logic [rtmpm_pkg::MIN_W-1:0] r_min;
    logic [TLW-1:0]              r_tlen, n_tlen;
    logic                        r_tovf, n_tovf;
    logic [PW-1:0]               r_pos, n_pos;
    logic [PW-1:0]               r_j, n_j;
    logic [NW-1:0]               r_node, n_node;
    logic [SB-1:0]               r_wsym, n_wsym;
    logic [CW-1:0]               r_cnt, n_cnt;
    logic                        r_ovf, n_ovf;
    logic [MAW-1:0]              r_k, n_k;

    // memory ports
    logic                         edge_we, edge_re;
    logic [EAW-1:0]               edge_waddr, edge_raddr;
    logic [5:0]                   edge_wdata, edge_rdata;
    logic                         mark_we, mark_re;
    logic [NW-1:0]                mark_waddr, mark_raddr;
    logic [rtmpm_pkg::MARK_W-1:0] mark_wdata, mark_rdata;
    logic                         skip_we, skip_re;
    logic [SB-1:0]                skip_waddr, skip_raddr;
    logic [6:0]                   skip_wdata, skip_rdata;
    logic                         text_we, text_re;
    logic [TAW-1:0]               text_waddr, text_raddr;
    logic [SB-1:0]                text_wdata, text_rdata;
    logic                         match_we, match_re;
    logic [MAW-1:0]               match_waddr, match_raddr;
    logic [MDW-1:0]               match_wdata, match_rdata;

    logic          in_beat;
    logic [SB-1:0] in_sym;
    logic          node_ok;
    logic          child_ok;
    logic [PW-1:0] start_pos;
    logic [PW-1:0] shift;
    logic          search_done;
    logic          out_last;

    assign in_beat  = i_in_valid && o_in_ready;
    assign in_sym   = SB'(i_symbol);
    assign node_ok  = 32'(i_node) < TRIE_NODES;
    assign child_ok = (edge_rdata != 6'd0) && (32'(edge_rdata) < TRIE_NODES);
    // search ends when the minimum length is zero, at the end of text, or when the match store is full and overflowed
    assign search_done = (r_min == '0) || !(r_pos < PW'(r_tlen))
                         || (r_ovf && (r_cnt == CW'(MAX_MATCHES)));
    assign start_pos = r_pos - r_j + PW'(1);
    assign shift     = (skip_rdata == 7'd0) ? PW'(1) : PW'(skip_rdata);
    assign out_last  = (r_cnt == '0) || (CW'(r_k) == r_cnt - CW'(1));

    assign o_in_ready      = (r_state == rtmpm_pkg::S_LOAD);
    assign o_out_valid     = (r_state == rtmpm_pkg::S_SHOW);
    assign o_found         = (r_cnt != '0);
    assign o_match_pattern = o_found ? match_rdata[MDW-1:rtmpm_pkg::START_FW] : 6'd0;
    assign o_match_start   = o_found ? match_rdata[rtmpm_pkg::START_FW-1:0] : 10'd0;
    assign o_overflow      = r_ovf;
    assign o_end_of_search = out_last;

    // clear sweep, table and text writes
    always_comb begin
        edge_we    = 1'b0;
        edge_waddr = {NW'(i_node), in_sym};
        edge_wdata = i_child_node;
        mark_we    = 1'b0;
        mark_waddr = NW'(i_node);
        mark_wdata = i_has_pattern ? {1'b1, i_pattern_id} : '0;
        skip_we    = 1'b0;
        skip_waddr = in_sym;
        skip_wdata = i_skip_value;
        text_we    = 1'b0;
        text_waddr = TAW'(r_tlen);
        text_wdata = in_sym;
        if (r_state == rtmpm_pkg::S_CLEAR) begin
            edge_we    = 1'b1;
            edge_waddr = r_clr;
            edge_wdata = '0;
            mark_we    = 1'b1;
            mark_waddr = r_clr[EAW-1:SB];
            mark_wdata = '0;
            skip_we    = 1'b1;
            skip_waddr = r_clr[SB-1:0];
            skip_wdata = '0;
        end else if (in_beat) begin
            case (i_action)
                rtmpm_pkg::ACT_EDGE: edge_we = node_ok;
                rtmpm_pkg::ACT_MARK: mark_we = node_ok;
                rtmpm_pkg::ACT_SKIP: skip_we = 1'b1;
                rtmpm_pkg::ACT_TEXT: text_we = (r_tlen < TLW'(TEXT_DEPTH));
                default: ;
            endcase
        end
    end

    // sequencer: clear, load, trie walk per window, result delivery
    always_comb begin
        n_state = r_state;
        n_clr   = r_clr;
        n_tlen  = r_tlen;
        n_tovf  = r_tovf;
        n_pos   = r_pos;
        n_j     = r_j;
        n_node  = r_node;
        n_wsym  = r_wsym;
        n_cnt   = r_cnt;
        n_ovf   = r_ovf;
        n_k     = r_k;

        edge_re     = 1'b0;
        edge_raddr  = {r_node, text_rdata};
        mark_re     = 1'b0;
        mark_raddr  = NW'(edge_rdata);
        skip_re     = 1'b0;
        skip_raddr  = r_wsym;
        text_re     = 1'b0;
        text_raddr  = TAW'(r_pos - r_j);
        match_we    = 1'b0;
        match_waddr = MAW'(r_cnt);
        match_wdata = {mark_rdata[rtmpm_pkg::PAT_FW-1:0], rtmpm_pkg::START_FW'(start_pos)};
        match_re    = 1'b0;
        match_raddr = r_k;

        case (r_state)
            rtmpm_pkg::S_CLEAR: begin
                n_clr = r_clr + EAW'(1);
                if (r_clr == EAW'(EDEPTH - 1)) begin
                    n_state = rtmpm_pkg::S_LOAD;
                end
            end
            rtmpm_pkg::S_LOAD: begin
                if (in_beat && (i_action == rtmpm_pkg::ACT_TEXT)) begin
                    if (r_tlen < TLW'(TEXT_DEPTH)) begin
                        n_tlen = r_tlen + TLW'(1);
                    end else begin
                        n_tovf = 1'b1;
                    end
                    if (i_last_symbol) begin
                        n_ovf   = n_tovf;
                        n_cnt   = '0;
                        n_pos   = PW'(r_min) - PW'(1);
                        n_state = rtmpm_pkg::S_WIN;
                    end
                end
            end
            rtmpm_pkg::S_WIN: begin
                n_j    = '0;
                n_node = '0;
                if (search_done) begin
                    n_tlen  = '0;
                    n_tovf  = 1'b0;
                    n_k     = '0;
                    n_state = rtmpm_pkg::S_RD;
                end else begin
                    text_re    = 1'b1;
                    text_raddr = TAW'(r_pos);
                    n_state    = rtmpm_pkg::S_SYM;
                end
            end
            rtmpm_pkg::S_TXT: begin
                text_re = 1'b1;
                n_state = rtmpm_pkg::S_SYM;
            end
            rtmpm_pkg::S_SYM: begin
                if (r_j == '0) begin
                    n_wsym = text_rdata;
                end
                edge_re = 1'b1;
                n_state = rtmpm_pkg::S_EDGE;
            end
            rtmpm_pkg::S_EDGE: begin
                if (child_ok) begin
                    n_node  = NW'(edge_rdata);
                    n_j     = r_j + PW'(1);
                    mark_re = 1'b1;
                    n_state = rtmpm_pkg::S_MARK;
                end else begin
                    n_state = rtmpm_pkg::S_SKIP;
                end
            end
            rtmpm_pkg::S_MARK: begin
                if (mark_rdata[rtmpm_pkg::MARK_W-1] && (r_cnt == CW'(MAX_MATCHES))) begin
                    // one match too many: flag it and end the walk
                    n_ovf   = 1'b1;
                    n_state = rtmpm_pkg::S_SKIP;
                end else begin
                    if (mark_rdata[rtmpm_pkg::MARK_W-1]) begin
                        match_we = 1'b1;
                        n_cnt    = r_cnt + CW'(1);
                    end
                    n_state = (r_j <= r_pos) ? rtmpm_pkg::S_TXT : rtmpm_pkg::S_SKIP;
                end
            end
            rtmpm_pkg::S_SKIP: begin
                skip_re = 1'b1;
                n_state = rtmpm_pkg::S_ADV;
            end
            rtmpm_pkg::S_ADV: begin
                n_pos   = r_pos + shift;
                n_state = rtmpm_pkg::S_WIN;
            end
            rtmpm_pkg::S_RD: begin
                match_re = 1'b1;
                n_state  = rtmpm_pkg::S_SHOW;
            end
            rtmpm_pkg::S_SHOW: begin
                if (i_out_ready) begin
                    if (out_last) begin
                        n_state = rtmpm_pkg::S_LOAD;
                    end else begin
                        n_k     = r_k + MAW'(1);
                        n_state = rtmpm_pkg::S_RD;
                    end
                end
            end
            default: n_state = rtmpm_pkg::S_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rtmpm_pkg::S_CLEAR;
            r_clr   <= '0;
            r_min   <= rtmpm_pkg::MIN_W'(1);
            r_tlen  <= '0;
            r_tovf  <= 1'b0;
            r_cnt   <= '0;
            r_ovf   <= 1'b0;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_tlen  <= n_tlen;
            r_tovf  <= n_tovf;
            r_cnt   <= n_cnt;
            r_ovf   <= n_ovf;
            r_k     <= n_k;
            if (i_cfg_we) begin
                r_min <= i_cfg_wdata;
            end
        end
    end

    // walk payload registers
    always_ff @(posedge i_clk) begin
        r_pos  <= n_pos;
        r_j    <= n_j;
        r_node <= n_node;
        r_wsym <= n_wsym;
    end

    rtmpm_ram #(.WIDTH(6), .DEPTH(EDEPTH)) u_edge_ram (
        .i_clk(i_clk), .i_we(edge_we), .i_waddr(edge_waddr), .i_wdata(edge_wdata),
        .i_re(edge_re), .i_raddr(edge_raddr), .o_rdata(edge_rdata)
    );

    rtmpm_ram #(.WIDTH(rtmpm_pkg::MARK_W), .DEPTH(TRIE_NODES)) u_mark_ram (
        .i_clk(i_clk), .i_we(mark_we), .i_waddr(mark_waddr), .i_wdata(mark_wdata),
        .i_re(mark_re), .i_raddr(mark_raddr), .o_rdata(mark_rdata)
    );

    rtmpm_ram #(.WIDTH(7), .DEPTH(SYM_COUNT)) u_skip_ram (
        .i_clk(i_clk), .i_we(skip_we), .i_waddr(skip_waddr), .i_wdata(skip_wdata),
        .i_re(skip_re), .i_raddr(skip_raddr), .o_rdata(skip_rdata)
    );

    rtmpm_ram #(.WIDTH(SB), .DEPTH(TEXT_DEPTH)) u_text_ram (
        .i_clk(i_clk), .i_we(text_we), .i_waddr(text_waddr), .i_wdata(text_wdata),
        .i_re(text_re), .i_raddr(text_raddr), .o_rdata(text_rdata)
    );

    rtmpm_ram #(.WIDTH(MDW), .DEPTH(MAX_MATCHES)) u_match_ram (
        .i_clk(i_clk), .i_we(match_we), .i_waddr(match_waddr), .i_wdata(match_wdata),
        .i_re(match_re), .i_raddr(match_raddr), .o_rdata(match_rdata)
    );
endmodule

>>> sv/rtmpm_checker.sv
// port-level checker for the reverse trie matcher, bound to the top level
// depends on assert_macros.svh
`include "assert_macros.svh"

module rtmpm_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_in_ready,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic       o_found,
    input logic [5:0] o_match_pattern,
    input logic [9:0] o_match_start,
    input logic       o_end_of_search
);
    logic        empty_ok;
    logic        stalled;
    logic        last_beat;
    logic [15:0] held_fields;

    assign empty_ok    = o_end_of_search && (o_match_pattern == 6'd0)
                         && (o_match_start == 10'd0);
    assign stalled     = o_out_valid && !i_out_ready;
    assign last_beat   = o_out_valid && i_out_ready && o_end_of_search;
    assign held_fields = {o_match_pattern, o_match_start};

    // results and input beats never overlap
    `ASSERT_ALWAYS(a_no_overlap, !(o_out_valid && o_in_ready))
    // an end marker without a match carries zero fields and ends the search
    `ASSERT_ALWAYS(a_empty_marker, !(o_out_valid && !o_found) || empty_ok)
    // stalled result holds
    `ASSERT_NEXT(a_stall_hold, stalled, o_out_valid && $stable(held_fields))
    // after the final beat the block takes input again
    `ASSERT_NEXT(a_end_reload, last_beat, o_in_ready && !o_out_valid)
endmodule

bind reverse_trie_multi_pattern_matcher_core rtmpm_checker u_rtmpm_checker (
    .i_clk(i_clk),
    .i_rst_n(i_rst_n),
    .o_in_ready(o_in_ready),
    .o_out_valid(o_out_valid),
    .i_out_ready(i_out_ready),
    .o_found(o_found),
    .o_match_pattern(o_match_pattern),
    .o_match_start(o_match_start),
    .o_end_of_search(o_end_of_search)
);
